FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every rising edge outside reset.
`define RORL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ring lookup core: assertion failed");
// The condition must never be true at a rising edge outside reset.
`define RORL_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ring lookup core: forbidden condition seen");
`else
`define RORL_ASSERT(name, clk, rst, prop)
`define RORL_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

FILE: rtl/core/rorl_pkg.sv
// ----------------------------------------------------------------------------
// rorl_pkg
// Shared widths, command codes, token and hit types, and FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rorl_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int LEN_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int OFFSET_W = 20;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_FIND = 1'b1;

   // A lookup in flight. The base never needs more than OFFSET_W bits: the
   // walk only goes on while the running sum stays at or below the target.
   typedef struct packed {
      logic                active;
      logic [OFFSET_W-1:0] target;
      logic [OFFSET_W-1:0] base;
   } token_type;

   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    offset;
   } hit_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/ring_of_records_with_offset_lookup_core.sv
// ----------------------------------------------------------------------------
// ring_of_records_with_offset_lookup_core
// Ring of length/handle records with lookup of a byte offset into them.
// ----------------------------------------------------------------------------
// An add item writes the slot at the write index and gives no result; once
// the ring is full it replaces the oldest record. A find item enters a token
// at the cell of the oldest record; the token moves one cell per cycle around
// the ring, adding each record's length, until it reaches the record that
// holds the offset or has passed every record. A find on an empty ring loads
// its miss into the output register in the cycle it is accepted. The result
// sits in an output register, and a new item is taken while it waits as long
// as that register will be free; no item is taken during a walk.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ring_of_records_with_offset_lookup_core #(
   parameter int SLOTS = rorl_pkg::SLOTS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_command,
   input  wire  [rorl_pkg::LEN_W-1:0]        req_record_length,
   input  wire  [rorl_pkg::HANDLE_W-1:0]     req_record_handle,
   input  wire  [rorl_pkg::OFFSET_W-1:0]     req_byte_offset,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_found,
   output logic [rorl_pkg::HANDLE_W-1:0]     rsp_hit_handle,
   output logic [rorl_pkg::LEN_W-1:0]        rsp_offset_in_record
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   rorl_pkg::state_type           state_ff, state_in;
   logic [IDX_W-1:0]              write_index_ff, read_index_ff, wr_next;
   logic                          ring_full_ff;
   logic [CNT_W-1:0]              remaining_ff, remaining_in, count;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff;
   logic [rorl_pkg::HANDLE_W-1:0] rsp_hit_handle_ff;
   logic [rorl_pkg::LEN_W-1:0]    rsp_offset_ff;

   logic                          req_accept, add_accept;
   logic                          inject, flush, load_rsp;
   rorl_pkg::hit_type             rsp_load_val;
   rorl_pkg::token_type           inj_tok;

   rorl_pkg::token_type           tok_chain [SLOTS];
   rorl_pkg::hit_type             hit_vec   [SLOTS];
   logic [SLOTS-1:0]              tok_active;
   rorl_pkg::hit_type             any_hit;

   assign req_stall  = (state_ff == rorl_pkg::ST_WALK) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign add_accept = req_accept && (req_command == rorl_pkg::CMD_ADD);

   assign inj_tok.active = 1'b1;
   assign inj_tok.target = req_byte_offset;
   assign inj_tok.base   = '0;

   // The cells form a ring; cell 0 takes its token from the last cell.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      localparam int PREV = (i == 0) ? SLOTS - 1 : i - 1;
      rorl_pkg::token_type tok_in;
      logic                wr_sel;

      assign tok_in = (inject && (read_index_ff == IDX_W'(i))) ? inj_tok : tok_chain[PREV];
      assign wr_sel = add_accept && (write_index_ff == IDX_W'(i));

      rorl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .flush      (flush),
         .wr_en      (wr_sel),
         .wr_length  (req_record_length),
         .wr_handle  (req_record_handle),
         .tok_in     (tok_in),
         .tok_out    (tok_chain[i]),
         .tok_active (tok_active[i]),
         .hit_out    (hit_vec[i])
      );
   end

   // At most one cell holds the token, so an OR merges the hit reports.
   always_comb begin
      any_hit = '0;
      for (int i = 0; i < SLOTS; i++) begin
         any_hit = any_hit | hit_vec[i];
      end
   end

   assign wr_next = (write_index_ff == IDX_W'(SLOTS - 1)) ? '0 : write_index_ff + 1'b1;
   assign count   = ring_full_ff ? CNT_W'(SLOTS) : {{(CNT_W - IDX_W){1'b0}}, write_index_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         read_index_ff  <= '0;
         ring_full_ff   <= 1'b0;
      end else if (add_accept) begin
         write_index_ff <= wr_next;
         if (ring_full_ff) begin
            read_index_ff <= wr_next;
         end else if (wr_next == read_index_ff) begin
            ring_full_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      inject       = 1'b0;
      flush        = 1'b0;
      load_rsp     = 1'b0;
      rsp_load_val = '0;
      unique case (state_ff)
         rorl_pkg::ST_IDLE: begin
            if (req_accept && (req_command == rorl_pkg::CMD_FIND)) begin
               if (count == '0) begin
                  load_rsp = 1'b1;
               end else begin
                  inject       = 1'b1;
                  remaining_in = count;
                  state_in     = rorl_pkg::ST_WALK;
               end
            end
         end
         rorl_pkg::ST_WALK: begin
            if (any_hit.hit) begin
               load_rsp     = 1'b1;
               rsp_load_val = any_hit;
               flush        = 1'b1;
               state_in     = rorl_pkg::ST_IDLE;
            end else if (remaining_ff == CNT_W'(1)) begin
               load_rsp = 1'b1;
               flush    = 1'b1;
               state_in = rorl_pkg::ST_IDLE;
            end else begin
               remaining_in = remaining_ff - 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rorl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff      <= rsp_load_val.hit;
         rsp_hit_handle_ff <= rsp_load_val.handle;
         rsp_offset_ff     <= rsp_load_val.offset;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_hit_handle       = rsp_hit_handle_ff;
   assign rsp_offset_in_record = rsp_offset_ff;

   `RORL_ASSERT(a_single_token, clock, reset, $onehot0(tok_active))
   `RORL_ASSERT(a_walk_has_token, clock, reset, (state_ff == rorl_pkg::ST_WALK) |-> $onehot(tok_active))
   `RORL_ASSERT(a_walk_count_live, clock, reset, (state_ff == rorl_pkg::ST_WALK) |-> (remaining_ff != '0))
   `RORL_ASSERT(a_full_indexes_meet, clock, reset, ring_full_ff |-> (read_index_ff == write_index_ff))
   `RORL_ASSERT_NEVER(a_miss_is_clean, clock, reset, rsp_valid_ff && !rsp_found_ff && (rsp_hit_handle_ff != '0 || rsp_offset_ff != '0))

endmodule

`default_nettype wire

FILE: rtl/core/rorl_cell.sv
// ----------------------------------------------------------------------------
// rorl_cell
// One ring slot: holds a record and checks the lookup token passing through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rorl_cell (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             flush,
   input  wire                             wr_en,
   input  wire  [rorl_pkg::LEN_W-1:0]      wr_length,
   input  wire  [rorl_pkg::HANDLE_W-1:0]   wr_handle,
   input  wire  rorl_pkg::token_type       tok_in,
   output rorl_pkg::token_type             tok_out,
   output logic                            tok_active,
   output rorl_pkg::hit_type               hit_out
);

   logic [rorl_pkg::LEN_W-1:0]    length_ff;
   logic [rorl_pkg::HANDLE_W-1:0] handle_ff;
   rorl_pkg::token_type           token_ff;
   rorl_pkg::token_type           token_in;
   logic [rorl_pkg::OFFSET_W:0]   sum;
   logic [rorl_pkg::OFFSET_W-1:0] diff;
   logic                          hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         length_ff <= wr_length;
         handle_ff <= wr_handle;
      end
   end

   always_comb begin
      token_in = tok_in;
      if (flush) begin
         token_in.active = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.active <= 1'b0;
      end else begin
         token_ff.active <= token_in.active;
      end
      token_ff.target <= token_in.target;
      token_ff.base   <= token_in.base;
   end

   always_comb begin
      sum  = {1'b0, token_ff.base}
           + {{(rorl_pkg::OFFSET_W + 1 - rorl_pkg::LEN_W){1'b0}}, length_ff};
      hit  = token_ff.active && ({1'b0, token_ff.target} < sum);
      diff = token_ff.target - token_ff.base;

      tok_out.active = token_ff.active && !hit;
      tok_out.target = token_ff.target;
      tok_out.base   = sum[rorl_pkg::OFFSET_W-1:0];

      hit_out.hit    = hit;
      hit_out.handle = hit ? handle_ff : '0;
      hit_out.offset = hit ? diff[rorl_pkg::LEN_W-1:0] : '0;
   end

   assign tok_active = token_ff.active;

endmodule

`default_nettype wire

FILE: tb/sv/tb_ring_of_records_with_offset_lookup_core.sv
// ----------------------------------------------------------------------------
// tb_ring_of_records_with_offset_lookup_core
// Self-checking bench for the record ring and its byte-offset lookup.
// ----------------------------------------------------------------------------
// A queue of add and find items, directed first and random after, feeds a
// driver that offers them on the request channel with random gaps. Every
// accepted item updates a shadow ring; each accepted find predicts its hit,
// and the monitor compares every accepted result with the oldest prediction.
// The receiver stalls in random bursts and once holds off for a long
// stretch so that the block backs up and stalls its input.
`timescale 1ns / 1ps

module tb_ring_of_records_with_offset_lookup_core;

   localparam int RING_SLOTS   = rorl_pkg::SLOTS_DEFAULT;
   localparam int LEN_W        = rorl_pkg::LEN_W;
   localparam int HANDLE_W     = rorl_pkg::HANDLE_W;
   localparam int OFFSET_W     = rorl_pkg::OFFSET_W;
   localparam int RANDOM_ITEMS = 1400;
   localparam int TAIL_ITEMS   = 200;
   localparam int HOLD_AT_ITEM = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * RING_SLOTS + 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic                command;
      logic [LEN_W-1:0]    length;
      logic [HANDLE_W-1:0] handle;
      logic [OFFSET_W-1:0] offset;
   } ring_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = rorl_pkg::CMD_ADD;
   logic [LEN_W-1:0]    req_record_length = '0;
   logic [HANDLE_W-1:0] req_record_handle = '0;
   logic [OFFSET_W-1:0] req_byte_offset = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic [HANDLE_W-1:0] rsp_hit_handle;
   logic [LEN_W-1:0]    rsp_offset_in_record;

   ring_item_type       pending_items[$];
   rorl_pkg::hit_type   expected_hits[$];
   int unsigned         queued_lengths[$];

   // Shadow of the ring contents as seen by accepted items.
   logic [LEN_W-1:0]    shadow_length[RING_SLOTS];
   logic [HANDLE_W-1:0] shadow_handle[RING_SLOTS];
   int unsigned         shadow_wr = 0;
   int unsigned         shadow_rd = 0;
   bit                  shadow_full = 1'b0;

   bit          req_taken = 1'b0;
   int unsigned accepted_count = 0;
   int unsigned total_items = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_burst = 0;
   int unsigned hold_off = 0;
   bit          hold_done = 1'b0;

   wire quiet_phase = (accepted_count + TAIL_ITEMS >= total_items) ||
                      (accepted_count >= 700 && accepted_count < 850);

   ring_of_records_with_offset_lookup_core #(
      .SLOTS(RING_SLOTS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_record_length   (req_record_length),
      .req_record_handle   (req_record_handle),
      .req_byte_offset     (req_byte_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_hit_handle      (rsp_hit_handle),
      .rsp_offset_in_record(rsp_offset_in_record)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Sum of the lengths of the oldest count records the stimulus has queued.
   function automatic int unsigned queued_prefix(input int unsigned count);
      int unsigned sum;
      sum = 0;
      for (int k = 0; k < count && k < queued_lengths.size(); k++) begin
         sum += queued_lengths[k];
      end
      return sum;
   endfunction

   task automatic queue_add(input int unsigned length, input logic [HANDLE_W-1:0] handle);
      ring_item_type item;
      item.command = rorl_pkg::CMD_ADD;
      item.length  = LEN_W'(length);
      item.handle  = handle;
      item.offset  = OFFSET_W'($urandom);
      pending_items.push_back(item);
      queued_lengths.push_back(length & 16'hFFFF);
      if (queued_lengths.size() > RING_SLOTS) begin
         void'(queued_lengths.pop_front());
      end
   endtask

   task automatic queue_find(input int unsigned offset);
      ring_item_type item;
      item.command = rorl_pkg::CMD_FIND;
      item.length  = LEN_W'($urandom);
      item.handle  = $urandom;
      item.offset  = (offset > 32'hFFFFF) ? 20'hFFFFF : OFFSET_W'(offset);
      pending_items.push_back(item);
   endtask

   // Applies one accepted item to the shadow ring; a find predicts its hit.
   task automatic apply_ring_item(input logic command, input logic [LEN_W-1:0] length,
                                  input logic [HANDLE_W-1:0] handle,
                                  input logic [OFFSET_W-1:0] offset);
      rorl_pkg::hit_type hit;
      int unsigned       base;
      int unsigned       idx;
      int unsigned       count;
      if (command == rorl_pkg::CMD_ADD) begin
         shadow_length[shadow_wr] = length;
         shadow_handle[shadow_wr] = handle;
         shadow_wr = (shadow_wr + 1) % RING_SLOTS;
         if (shadow_full) begin
            shadow_rd = shadow_wr;
         end else if (shadow_wr == shadow_rd) begin
            shadow_full = 1'b1;
         end
      end else begin
         hit   = '0;
         base  = 0;
         idx   = shadow_rd;
         count = shadow_full ? RING_SLOTS : shadow_wr;
         for (int k = 0; k < count && !hit.hit; k++) begin
            if (offset < base + shadow_length[idx]) begin
               hit.hit    = 1'b1;
               hit.handle = shadow_handle[idx];
               hit.offset = LEN_W'(offset - base);
            end else begin
               base += shadow_length[idx];
               idx = (idx + 1) % RING_SLOTS;
            end
         end
         expected_hits.push_back(hit);
      end
   endtask

   task automatic fill_random_items();
      int unsigned total;
      int unsigned pick;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 9) < 4) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               queue_add(0, $urandom);
            end else if (pick < 3) begin
               queue_add($urandom_range(0, 16'hFFFF), $urandom);
            end else begin
               queue_add($urandom_range(1, 300), $urandom);
            end
         end else begin
            total = queued_prefix(RING_SLOTS);
            pick  = $urandom_range(0, 19);
            if (pick < 13) begin
               queue_find($urandom_range(0, total + 16));
            end else if (pick < 17) begin
               // Land on or just before a record boundary.
               total = queued_prefix($urandom_range(0, RING_SLOTS));
               queue_find((total > 0 && $urandom_range(0, 1)) ? total - 1 : total);
            end else begin
               queue_find($urandom_range(0, 20'hFFFFF));
            end
         end
      end
   endtask

   initial begin
      // Empty ring, then a zero-length record alone.
      queue_find(0);
      queue_find(20'hFFFFF);
      queue_add(0, 32'hFFFF_FFFF);
      queue_find(0);
      // Largest record, probed at its first byte, last byte and one past it.
      queue_add(16'hFFFF, 32'h0000_0000);
      queue_find(0);
      queue_find(16'hFFFE);
      queue_find(16'hFFFF);
      queue_add(1, 32'hA5A5_5A5A);
      queue_find(16'hFFFF);
      for (int k = 0; k < RING_SLOTS - 3; k++) begin
         queue_add(16'hFFFF, $urandom);
      end
      queue_find(queued_prefix(RING_SLOTS) - 1);
      queue_find(20'hFFFFF);
      // Wrap: the zero-length and the first large record are replaced.
      queue_add(16'hFFFF, 32'h1234_5678);
      queue_add(16'hFFFF, 32'h8765_4321);
      queue_find(0);
      queue_add(16'hFFFF, 32'hFFFF_0000);
      queue_find(queued_prefix(RING_SLOTS) - 1);
      queue_find(20'hFFFFF);
      fill_random_items();
      total_items = pending_items.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_hits.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Request driver: a stalled item is held as it is until it is taken.
   always @(negedge clock) begin
      ring_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap == 0 && !quiet_phase && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 8);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            item = pending_items.pop_front();
            req_valid         <= 1'b1;
            req_command       <= item.command;
            req_record_length <= item.length;
            req_record_handle <= item.handle;
            req_byte_offset   <= item.offset;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall bursts plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_count >= HOLD_AT_ITEM) begin
         hold_done = 1'b1;
         hold_off  = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (quiet_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_burst = $urandom_range(1, 8) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predicts on accepted items and checks accepted results.
   always @(posedge clock) begin
      rorl_pkg::hit_type got;
      rorl_pkg::hit_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            accepted_count++;
            apply_ring_item(req_command, req_record_length, req_record_handle,
                            req_byte_offset);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_found, rsp_hit_handle, rsp_offset_in_record};
            if (expected_hits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result with none expected: found=%0b handle=%h offset=%0d",
                           $realtime, got.hit, got.handle, got.offset);
               end
            end else begin
               want = expected_hits.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: lookup mismatch: found %0b/%0b handle %h/%h offset %0d/%0d",
                              $realtime, want.hit, got.hit, want.handle, got.handle,
                              want.offset, got.offset);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
